// ----- src/saf_pkg.sv -----
// Shared opcodes, stage structs and width helpers for the saturating flag ALU.
`timescale 1ns / 1ps

package saf_pkg;

  localparam logic [3:0] OP_ADD_SAT_S = 4'd0;
  localparam logic [3:0] OP_ADD_SAT_U = 4'd1;
  localparam logic [3:0] OP_SUB_SAT_S = 4'd2;
  localparam logic [3:0] OP_SUB_SAT_U = 4'd3;
  localparam logic [3:0] OP_MUL_SAT_S = 4'd4;
  localparam logic [3:0] OP_MUL_SAT_U = 4'd5;
  localparam logic [3:0] OP_ADD       = 4'd6;
  localparam logic [3:0] OP_SUB       = 4'd7;
  localparam logic [3:0] OP_MUL       = 4'd8;
  localparam logic [3:0] OP_SHL       = 4'd9;
  localparam logic [3:0] OP_SAR       = 4'd10;
  localparam logic [3:0] OP_SHR       = 4'd11;
  localparam logic [3:0] OP_NEG       = 4'd12;

  localparam logic [1:0] W8  = 2'd0;
  localparam logic [1:0] W16 = 2'd1;
  localparam logic [1:0] W32 = 2'd2;
  localparam logic [1:0] W64 = 2'd3;

  // decoded operands
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  wsel;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] a_sx;
    logic [5:0]  n;
    logic        cin;
  } s1_t;

  // add/sub/shift/neg done, partial products formed
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  wsel;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  n;
    logic [63:0] res;
    logic        cf;
    logic        vf;
    logic [63:0] pp_ll;
    logic [63:0] pp_lh;
    logic [63:0] pp_hl;
    logic [63:0] pp_hh;
  } s2_t;

  // full product and signed correction
  typedef struct packed {
    logic [3:0]   op;
    logic [1:0]   wsel;
    logic [63:0]  res;
    logic         cf;
    logic         vf;
    logic         mul_neg;
    logic [63:0]  corr;
    logic [127:0] prod;
  } s3_t;

  typedef struct packed {
    logic [63:0] result;
    logic        zero_flag;
    logic        negative_flag;
    logic        carry_flag;
    logic        overflow_flag;
  } res_t;

  function automatic logic [63:0] width_mask(input logic [1:0] wsel);
    logic [63:0] m;
    unique case (wsel)
      W8:      m = 64'h0000_0000_0000_00FF;
      W16:     m = 64'h0000_0000_0000_FFFF;
      W32:     m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic sign_bit(input logic [63:0] v, input logic [1:0] wsel);
    logic s;
    unique case (wsel)
      W8:      s = v[7];
      W16:     s = v[15];
      W32:     s = v[31];
      default: s = v[63];
    endcase
    return s;
  endfunction

  // bit just above the width in a 65-bit value
  function automatic logic carry_bit(input logic [64:0] v, input logic [1:0] wsel);
    logic c;
    unique case (wsel)
      W8:      c = v[8];
      W16:     c = v[16];
      W32:     c = v[32];
      default: c = v[64];
    endcase
    return c;
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] wsel);
    logic [63:0] x;
    unique case (wsel)
      W8:      x = {{56{v[7]}}, v[7:0]};
      W16:     x = {{48{v[15]}}, v[15:0]};
      W32:     x = {{32{v[31]}}, v[31:0]};
      default: x = v;
    endcase
    return x;
  endfunction

endpackage

// ----- src/saf_decode.sv -----
// Stage 1: operand masking, sign extension, shift count and carry-in qualification.
`timescale 1ns / 1ps

module saf_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [3:0]        opcode,
  input  logic [1:0]        width_sel,
  input  logic [63:0]       operand_a,
  input  logic [63:0]       operand_b,
  input  logic              carry_in,
  input  logic              carry_in_used,
  output logic              dn_valid,
  input  logic              dn_ready,
  output saf_pkg::s1_t      dn_data
);
  import saf_pkg::*;

  logic        valid_r;
  s1_t         data_r;
  s1_t         data_nxt;
  logic [63:0] m;
  logic [5:0]  nmask;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    m = width_mask(width_sel);
    // shift count is taken modulo the width
    unique case (width_sel)
      W8:      nmask = 6'd7;
      W16:     nmask = 6'd15;
      W32:     nmask = 6'd31;
      default: nmask = 6'd63;
    endcase
    data_nxt.op   = opcode;
    data_nxt.wsel = width_sel;
    data_nxt.a    = operand_a & m;
    data_nxt.b    = operand_b & m;
    data_nxt.a_sx = sext(operand_a & m, width_sel);
    data_nxt.n    = operand_b[5:0] & nmask;
    data_nxt.cin  = carry_in && carry_in_used && (opcode == OP_ADD || opcode == OP_SUB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/saf_exec.sv -----
// Stage 2: adders, shifters, negate, saturating add/sub and 32x32 partial products.
`timescale 1ns / 1ps

module saf_exec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  saf_pkg::s1_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output saf_pkg::s2_t  dn_data
);
  import saf_pkg::*;

  logic               valid_r;
  s2_t                data_r;
  s2_t                data_nxt;
  logic [63:0]        m;
  logic [63:0]        minv;
  logic [63:0]        maxs;
  logic [64:0]        sum65;
  logic [64:0]        diff65;
  logic [63:0]        sum_r;
  logic [63:0]        diff_r;
  logic               add_c;
  logic               sub_b;
  logic               add_v;
  logic               sub_v;
  logic [64:0]        shl65;
  logic [64:0]        shr65;
  logic signed [64:0] sar65;
  logic [63:0]        neg_r;
  logic [31:0]        a_lo;
  logic [31:0]        a_hi;
  logic [31:0]        b_lo;
  logic [31:0]        b_hi;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  assign a_lo = up_data.a[31:0];
  assign a_hi = up_data.a[63:32];
  assign b_lo = up_data.b[31:0];
  assign b_hi = up_data.b[63:32];

  always_comb begin
    m      = width_mask(up_data.wsel);
    maxs   = m >> 1;
    minv   = m ^ maxs;
    sum65  = {1'b0, up_data.a} + {1'b0, up_data.b} + {64'd0, up_data.cin};
    diff65 = {1'b0, up_data.a} - {1'b0, up_data.b} - {64'd0, up_data.cin};
    sum_r  = sum65[63:0] & m;
    diff_r = diff65[63:0] & m;
    add_c  = carry_bit(sum65, up_data.wsel);
    sub_b  = diff65[64];
    add_v  = sign_bit((up_data.a ^ sum_r) & (up_data.b ^ sum_r), up_data.wsel);
    sub_v  = sign_bit((up_data.a ^ up_data.b) & (up_data.a ^ diff_r), up_data.wsel);
    // bit 0 of the right shifters is the last bit moved out
    shl65  = {1'b0, up_data.a} << up_data.n;
    shr65  = {up_data.a, 1'b0} >> up_data.n;
    sar65  = $signed({up_data.a_sx, 1'b0}) >>> up_data.n;
    neg_r  = (64'd0 - up_data.a) & m;

    data_nxt.op    = up_data.op;
    data_nxt.wsel  = up_data.wsel;
    data_nxt.a     = up_data.a;
    data_nxt.b     = up_data.b;
    data_nxt.n     = up_data.n;
    data_nxt.res   = '0;
    data_nxt.cf    = 1'b0;
    data_nxt.vf    = 1'b0;
    data_nxt.pp_ll = a_lo * b_lo;
    data_nxt.pp_lh = a_lo * b_hi;
    data_nxt.pp_hl = a_hi * b_lo;
    data_nxt.pp_hh = a_hi * b_hi;

    case (up_data.op)
      OP_ADD_SAT_S: begin
        data_nxt.res = add_v ? (sign_bit(up_data.a, up_data.wsel) ? minv : maxs) : sum_r;
      end
      OP_ADD_SAT_U: begin
        data_nxt.res = add_c ? m : sum_r;
      end
      OP_SUB_SAT_S: begin
        data_nxt.res = sub_v ? (sign_bit(up_data.a, up_data.wsel) ? minv : maxs) : diff_r;
      end
      OP_SUB_SAT_U: begin
        data_nxt.res = sub_b ? '0 : diff_r;
      end
      OP_ADD: begin
        data_nxt.res = sum_r;
        data_nxt.cf  = add_c;
        data_nxt.vf  = add_v;
      end
      OP_SUB: begin
        data_nxt.res = diff_r;
        data_nxt.cf  = sub_b;
        data_nxt.vf  = sub_v;
      end
      OP_SHL: begin
        data_nxt.res = shl65[63:0] & m;
        data_nxt.cf  = carry_bit(shl65, up_data.wsel);
      end
      OP_SAR: begin
        data_nxt.res = sar65[64:1] & m;
        data_nxt.cf  = sar65[0];
      end
      OP_SHR: begin
        data_nxt.res = shr65[64:1];
        data_nxt.cf  = shr65[0];
      end
      OP_NEG: begin
        data_nxt.res = neg_r;
        data_nxt.cf  = up_data.a != '0;
        data_nxt.vf  = sign_bit(up_data.a & neg_r, up_data.wsel);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/saf_mulsum.sv -----
// Stage 3: partial product summation, signed high-part correction, lossy shl check.
`timescale 1ns / 1ps

module saf_mulsum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  saf_pkg::s2_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output saf_pkg::s3_t  dn_data
);
  import saf_pkg::*;

  logic               valid_r;
  s3_t                data_r;
  s3_t                data_nxt;
  logic [63:0]        m;
  logic               sa;
  logic               sb;
  logic signed [63:0] sres;
  logic signed [63:0] back;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    m    = width_mask(up_data.wsel);
    sa   = sign_bit(up_data.a, up_data.wsel);
    sb   = sign_bit(up_data.b, up_data.wsel);
    sres = $signed(sext(up_data.res, up_data.wsel));
    back = sres >>> up_data.n;

    data_nxt.op      = up_data.op;
    data_nxt.wsel    = up_data.wsel;
    data_nxt.res     = up_data.res;
    data_nxt.cf      = up_data.cf;
    data_nxt.vf      = up_data.vf;
    data_nxt.mul_neg = sa ^ sb;
    // high half of signed product = unsigned high minus this
    data_nxt.corr    = (sa ? up_data.b : 64'd0) + (sb ? up_data.a : 64'd0);
    data_nxt.prod    = {64'd0, up_data.pp_ll}
                     + {32'd0, up_data.pp_lh, 32'd0}
                     + {32'd0, up_data.pp_hl, 32'd0}
                     + {up_data.pp_hh, 64'd0};
    if (up_data.op == OP_SHL) begin
      data_nxt.vf = (64'(back) & m) != up_data.a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/saf_final.sv -----
// Stage 4: multiply overflow and saturation, flag generation, output register.
`timescale 1ns / 1ps

module saf_final (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  saf_pkg::s3_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output saf_pkg::res_t dn_data
);
  import saf_pkg::*;

  logic        valid_r;
  res_t        data_r;
  res_t        data_nxt;
  logic [63:0] m;
  logic [63:0] minv;
  logic [63:0] maxs;
  logic [63:0] uhigh;
  logic [63:0] shigh;
  logic [63:0] r_mul;
  logic [63:0] r;
  logic        ov_u;
  logic        ov_s;
  logic        cf;
  logic        vf;
  logic        flagop;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    m    = width_mask(up_data.wsel);
    maxs = m >> 1;
    minv = m ^ maxs;
    unique case (up_data.wsel)
      W8:      uhigh = {56'd0, up_data.prod[15:8]};
      W16:     uhigh = {48'd0, up_data.prod[31:16]};
      W32:     uhigh = {32'd0, up_data.prod[63:32]};
      default: uhigh = up_data.prod[127:64];
    endcase
    r_mul = up_data.prod[63:0] & m;
    shigh = (uhigh - up_data.corr) & m;
    ov_u  = uhigh != '0;
    ov_s  = shigh != (sign_bit(r_mul, up_data.wsel) ? m : 64'd0);

    r  = up_data.res;
    cf = up_data.cf;
    vf = up_data.vf;
    case (up_data.op)
      OP_MUL_SAT_S: r = ov_s ? (up_data.mul_neg ? minv : maxs) : r_mul;
      OP_MUL_SAT_U: r = ov_u ? m : r_mul;
      OP_MUL: begin
        r  = r_mul;
        cf = ov_u;
        vf = ov_s;
      end
      default: ;
    endcase

    flagop                 = (up_data.op >= OP_ADD) && (up_data.op <= OP_NEG);
    data_nxt.result        = r;
    data_nxt.zero_flag     = flagop && (r == '0);
    data_nxt.negative_flag = flagop && sign_bit(r, up_data.wsel);
    data_nxt.carry_flag    = flagop && cf;
    data_nxt.overflow_flag = flagop && vf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/saturating_flag_alu_core.sv -----
// Saturating flag ALU top: four-stage pipeline, one beat per cycle unless stalled.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | opcode, width_sel, operand_a/b, carry_in(_used)
// out     | out_valid / out_ready| result, zero/negative/carry/overflow flags
//
// Throughput is one beat per cycle unless out_ready stalls; the result
// passes the decode, exec, mulsum and final registers after accept. The
// depth is set by the 64x64 multiply, split into 32x32 partial products,
// a 128-bit partial product sum, and the high-half and saturation stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage takes a new beat when it is empty or its successor takes its
// beat, so a stall at out_ready backs up stage by stage and empty slots close.

module saturating_flag_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [1:0]  in_width_sel,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic        in_carry_in,
  input  logic        in_carry_in_used,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  output logic        out_zero_flag,
  output logic        out_negative_flag,
  output logic        out_carry_flag,
  output logic        out_overflow_flag
);
  import saf_pkg::*;

  // stage-to-stage handshakes
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;
  logic s3_valid;
  logic s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  res_t res;

  // stage 1: mask operands to width, sign extend, shift count, carry-in gate
  saf_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_valid),
    .up_ready      (in_ready),
    .opcode        (in_opcode),
    .width_sel     (in_width_sel),
    .operand_a     (in_operand_a),
    .operand_b     (in_operand_b),
    .carry_in      (in_carry_in),
    .carry_in_used (in_carry_in_used),
    .dn_valid      (s1_valid),
    .dn_ready      (s1_ready),
    .dn_data       (s1_data)
  );

  // stage 2: add/sub with carry, barrel shifters, negate, partial products
  saf_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // stage 3: 128-bit product, signed correction term, lossy left shift test
  saf_mulsum u_mulsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // stage 4: multiply overflow, saturation, flags; doubles as output register
  saf_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_result        = res.result;
  assign out_zero_flag     = res.zero_flag;
  assign out_negative_flag = res.negative_flag;
  assign out_carry_flag    = res.carry_flag;
  assign out_overflow_flag = res.overflow_flag;

endmodule
